// ===== rtl/lrpe_pkg.sv =====
// lrpe_pkg: shared types and codes of the lr table parse engine
`default_nettype none

package lrpe_pkg;

    typedef enum logic [1:0] {
        FUNC_ACTION = 2'd0,
        FUNC_GOTO   = 2'd1,
        FUNC_RULE   = 2'd2,
        FUNC_TOKEN  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_ACCEPT = 2'd3
    } act_kind_t;

    typedef enum logic [2:0] {
        EV_REDUCE = 3'd0,
        EV_SHIFT  = 3'd1,
        EV_ACCEPT = 3'd2,
        EV_NOACT  = 3'd3,
        EV_NOGOTO = 3'd4,
        EV_STACK  = 3'd5,
        EV_LIMIT  = 3'd6
    } ev_kind_t;

    localparam int unsigned LIMIT_RESET = 63;

    // one classified command between the front and the back
    typedef struct packed {
        func_t       func;
        logic [7:0]  table_state;
        logic [5:0]  table_symbol;
        logic [1:0]  entry_kind;
        logic [7:0]  entry_target;
        logic [6:0]  rule_index;
        logic [5:0]  rule_lhs;
        logic [3:0]  rule_length;
        logic [5:0]  token_symbol;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lrpe_ram.sv =====
// lrpe_ram: generic single write port, single read port ram with registered read
`default_nettype none

module lrpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrpe_front.sv =====
// lrpe_front: input acceptance, range classification and two-entry command queue
`default_nettype none

module lrpe_front #(
    parameter int STATE_COUNT  = 256,
    parameter int SYMBOL_COUNT = 64,
    parameter int RULE_COUNT   = 128
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    func,
    input  wire logic [7:0]    table_state,
    input  wire logic [5:0]    table_symbol,
    input  wire logic [1:0]    entry_kind,
    input  wire logic [7:0]    entry_target,
    input  wire logic [6:0]    rule_index,
    input  wire logic [5:0]    rule_lhs,
    input  wire logic [3:0]    rule_length,
    input  wire logic [5:0]    token_symbol,
    input  wire logic          hold,
    output logic               cmd_valid,
    output lrpe_pkg::cmd_t     cmd,
    input  wire logic          cmd_pop
);

    lrpe_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           accept, keep, push;
    lrpe_pkg::cmd_t item;

    assign in_stall = (count_reg == 2'd2) || hold;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item.func         = lrpe_pkg::func_t'(func);
        item.table_state  = table_state;
        item.table_symbol = table_symbol;
        item.entry_kind   = entry_kind;
        item.entry_target = entry_target;
        item.rule_index   = rule_index;
        item.rule_lhs     = rule_lhs;
        item.rule_length  = rule_length;
        item.token_symbol = token_symbol;
        case (item.func)
            lrpe_pkg::FUNC_ACTION, lrpe_pkg::FUNC_GOTO:
                keep = (32'(table_state) < STATE_COUNT) &&
                       (32'(table_symbol) < SYMBOL_COUNT);
            lrpe_pkg::FUNC_RULE:
                keep = 32'(rule_index) < RULE_COUNT;
            default:
                keep = 1'b1;
        endcase
    end

    // out of range table writes are dropped here
    assign push      = accept && keep;
    assign cmd_valid = count_reg != 2'd0;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrpe_back.sv =====
// lrpe_back: table stores, state stack and the shift-reduce sequencer
`default_nettype none

module lrpe_back #(
    parameter int STATE_COUNT  = 256,
    parameter int SYMBOL_COUNT = 64,
    parameter int RULE_COUNT   = 128,
    parameter int STACK_DEPTH  = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [5:0]    reduce_limit,
    output logic               clearing,
    input  wire logic          cmd_valid,
    input  lrpe_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         event_kind,
    output logic [6:0]         production,
    output logic [7:0]         top_state,
    output logic               last
);

    localparam int TBL_DEPTH = STATE_COUNT * SYMBOL_COUNT;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int RULE_AW   = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int STK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W      = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ACT   = 7'b0000100,
        S_ACTW  = 7'b0001000,
        S_RULE  = 7'b0010000,
        S_EXP   = 7'b0100000,
        S_GOTO  = 7'b1000000
    } seq_state_t;

    seq_state_t          state_reg, state_next;
    logic [TBL_AW-1:0]   clr_reg, clr_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [7:0]          top_reg, top_next;
    logic [5:0]          tok_reg, tok_next;
    logic [5:0]          red_reg, red_next;
    logic [6:0]          prod_reg, prod_next;
    logic [5:0]          lhs_reg, lhs_next;
    logic [SP_W-1:0]     remain_reg, remain_next;
    logic                exp_zero_reg, exp_zero_next;

    logic                out_valid_reg;
    logic [2:0]          kind_reg;
    logic [6:0]          prod_out_reg;
    logic [7:0]          top_out_reg;
    logic                last_reg;

    logic                act_we, act_re, goto_we, goto_re, rule_we, rule_re, stk_we, stk_re;
    logic [TBL_AW-1:0]   act_waddr, act_raddr, goto_waddr, goto_raddr;
    logic [9:0]          act_wdata, act_rdata;
    logic [8:0]          goto_wdata, goto_rdata;
    logic [RULE_AW-1:0]  rule_waddr, rule_raddr;
    logic [9:0]          rule_wdata, rule_rdata;
    logic [STK_AW-1:0]   stk_waddr, stk_raddr;
    logic [7:0]          stk_wdata, stk_rdata;

    logic                out_free, do_emit;
    lrpe_pkg::ev_kind_t  em_kind;
    logic [6:0]          em_prod;
    logic [7:0]          em_top;
    logic                em_last;
    logic [7:0]          exposed;
    logic [31:0]         remain_w;

    lrpe_ram #(.WIDTH(10), .DEPTH(TBL_DEPTH)) u_action (
        .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
        .re(act_re), .raddr(act_raddr), .rdata(act_rdata)
    );
    lrpe_ram #(.WIDTH(9), .DEPTH(TBL_DEPTH)) u_goto (
        .clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
        .re(goto_re), .raddr(goto_raddr), .rdata(goto_rdata)
    );
    lrpe_ram #(.WIDTH(10), .DEPTH(RULE_COUNT)) u_rule (
        .clk(clk), .we(rule_we), .waddr(rule_waddr), .wdata(rule_wdata),
        .re(rule_re), .raddr(rule_raddr), .rdata(rule_rdata)
    );
    lrpe_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign clearing = state_reg == S_CLEAR;
    assign out_free = !out_valid_reg || !out_stall;
    // bottom entry is never written and always holds state zero
    assign exposed  = exp_zero_reg ? 8'd0 : stk_rdata;
    assign remain_w = 32'(sp_reg) - 32'(rule_rdata[3:0]);

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        tok_next      = tok_reg;
        red_next      = red_reg;
        prod_next     = prod_reg;
        lhs_next      = lhs_reg;
        remain_next   = remain_reg;
        exp_zero_next = exp_zero_reg;
        cmd_pop       = 1'b0;
        act_we = 1'b0; act_re = 1'b0; goto_we = 1'b0; goto_re = 1'b0;
        rule_we = 1'b0; rule_re = 1'b0; stk_we = 1'b0; stk_re = 1'b0;
        act_waddr  = '0; act_raddr  = '0; act_wdata  = '0;
        goto_waddr = '0; goto_raddr = '0; goto_wdata = '0;
        rule_waddr = '0; rule_raddr = '0; rule_wdata = '0;
        stk_waddr  = '0; stk_raddr  = '0; stk_wdata  = '0;
        do_emit = 1'b0;
        em_kind = lrpe_pkg::EV_NOACT;
        em_prod = 7'd0;
        em_top  = 8'd0;
        em_last = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                act_we     = 1'b1;
                act_waddr  = clr_reg;
                goto_we    = 1'b1;
                goto_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == TBL_AW'(TBL_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.func)
                        lrpe_pkg::FUNC_ACTION:
                        begin
                            act_we    = 1'b1;
                            act_waddr = TBL_AW'(32'(cmd.table_state) * SYMBOL_COUNT
                                                + 32'(cmd.table_symbol));
                            act_wdata = {cmd.entry_kind, cmd.entry_target};
                        end
                        lrpe_pkg::FUNC_GOTO:
                        begin
                            goto_we    = 1'b1;
                            goto_waddr = TBL_AW'(32'(cmd.table_state) * SYMBOL_COUNT
                                                 + 32'(cmd.table_symbol));
                            goto_wdata = {cmd.entry_kind != 2'd0, cmd.entry_target};
                        end
                        lrpe_pkg::FUNC_RULE:
                        begin
                            rule_we    = 1'b1;
                            rule_waddr = RULE_AW'(cmd.rule_index);
                            rule_wdata = {cmd.rule_lhs, cmd.rule_length};
                        end
                        default:
                        begin
                            tok_next   = cmd.token_symbol;
                            red_next   = 6'd0;
                            state_next = S_ACT;
                        end
                    endcase
                end
            end
            S_ACT:
            begin
                if (out_free)
                begin
                    if ((32'(top_reg) >= STATE_COUNT) || (32'(tok_reg) >= SYMBOL_COUNT))
                    begin
                        do_emit = 1'b1;
                        em_kind = lrpe_pkg::EV_NOACT;
                    end
                    else
                    begin
                        act_re     = 1'b1;
                        act_raddr  = TBL_AW'(32'(top_reg) * SYMBOL_COUNT + 32'(tok_reg));
                        state_next = S_ACTW;
                    end
                end
            end
            S_ACTW:
            begin
                if (out_free)
                begin
                    case (lrpe_pkg::act_kind_t'(act_rdata[9:8]))
                        lrpe_pkg::ACT_SHIFT:
                        begin
                            do_emit = 1'b1;
                            if (32'(sp_reg) >= STACK_DEPTH)
                            begin
                                em_kind = lrpe_pkg::EV_STACK;
                            end
                            else
                            begin
                                em_kind   = lrpe_pkg::EV_SHIFT;
                                em_top    = act_rdata[7:0];
                                stk_we    = 1'b1;
                                stk_waddr = STK_AW'(sp_reg);
                                stk_wdata = act_rdata[7:0];
                            end
                        end
                        lrpe_pkg::ACT_ACCEPT:
                        begin
                            do_emit = 1'b1;
                            em_kind = lrpe_pkg::EV_ACCEPT;
                        end
                        lrpe_pkg::ACT_REDUCE:
                        begin
                            if (red_reg >= reduce_limit)
                            begin
                                do_emit = 1'b1;
                                em_kind = lrpe_pkg::EV_LIMIT;
                            end
                            else if (32'(act_rdata[7:0]) >= RULE_COUNT)
                            begin
                                do_emit = 1'b1;
                                em_kind = lrpe_pkg::EV_NOACT;
                            end
                            else
                            begin
                                rule_re    = 1'b1;
                                rule_raddr = RULE_AW'(act_rdata[7:0]);
                                prod_next  = act_rdata[6:0];
                                state_next = S_RULE;
                            end
                        end
                        default:
                        begin
                            do_emit = 1'b1;
                            em_kind = lrpe_pkg::EV_NOACT;
                        end
                    endcase
                end
            end
            S_RULE:
            begin
                if (out_free)
                begin
                    if ((32'(rule_rdata[3:0]) >= 32'(sp_reg)) || (remain_w >= STACK_DEPTH))
                    begin
                        do_emit = 1'b1;
                        em_kind = lrpe_pkg::EV_STACK;
                    end
                    else
                    begin
                        stk_re        = 1'b1;
                        stk_raddr     = STK_AW'(remain_w - 32'd1);
                        exp_zero_next = remain_w == 32'd1;
                        remain_next   = SP_W'(remain_w);
                        lhs_next      = rule_rdata[9:4];
                        state_next    = S_EXP;
                    end
                end
            end
            S_EXP:
            begin
                if (out_free)
                begin
                    if ((32'(exposed) >= STATE_COUNT) || (32'(lhs_reg) >= SYMBOL_COUNT))
                    begin
                        do_emit = 1'b1;
                        em_kind = lrpe_pkg::EV_NOGOTO;
                    end
                    else
                    begin
                        goto_re    = 1'b1;
                        goto_raddr = TBL_AW'(32'(exposed) * SYMBOL_COUNT + 32'(lhs_reg));
                        state_next = S_GOTO;
                    end
                end
            end
            S_GOTO:
            begin
                if (out_free)
                begin
                    do_emit = 1'b1;
                    if (!goto_rdata[8])
                    begin
                        em_kind = lrpe_pkg::EV_NOGOTO;
                    end
                    else
                    begin
                        em_kind   = lrpe_pkg::EV_REDUCE;
                        em_prod   = prod_reg;
                        em_top    = goto_rdata[7:0];
                        em_last   = 1'b0;
                        stk_we    = 1'b1;
                        stk_waddr = STK_AW'(remain_reg);
                        stk_wdata = goto_rdata[7:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // every final event ends the token; all but shift leave a fresh stack
        if (do_emit)
        begin
            case (em_kind)
                lrpe_pkg::EV_REDUCE:
                begin
                    sp_next    = remain_reg + 1'b1;
                    top_next   = goto_rdata[7:0];
                    red_next   = red_reg + 1'b1;
                    state_next = S_ACT;
                end
                lrpe_pkg::EV_SHIFT:
                begin
                    sp_next    = sp_reg + 1'b1;
                    top_next   = act_rdata[7:0];
                    state_next = S_IDLE;
                end
                default:
                begin
                    sp_next    = SP_W'(1);
                    top_next   = 8'd0;
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg      <= tok_next;
        red_reg      <= red_next;
        prod_reg     <= prod_next;
        lhs_reg      <= lhs_next;
        remain_reg   <= remain_next;
        exp_zero_reg <= exp_zero_next;
        if (do_emit)
        begin
            kind_reg     <= em_kind;
            prod_out_reg <= em_prod;
            top_out_reg  <= em_top;
            last_reg     <= em_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= SP_W'(1);
            top_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            top_reg   <= top_next;
            if (do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign production = prod_out_reg;
    assign top_state  = top_out_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== rtl/lr_table_parse_engine_top.sv =====
// lr_table_parse_engine_top: table-driven lr shift-reduce parser driver, top level
// table writes: queued in the front, then written to their store when the idle sequencer
// pops them; with the sequencer idle, a token passes the command queue, the idle, act and
// act-wait states and the output register before its first result is presented; an action
// lookup uses the act and act-wait states, each reduction then reads the rule, stack and
// goto stores in turn, each read needing the one before, and then starts a fresh lookup;
// reset: the action and goto stores are swept to empty, one entry a cycle, over all
// STATE_COUNT*SYMBOL_COUNT entries (16384 by default); no item is taken during that pass
`default_nettype none

module lr_table_parse_engine_top #(
    parameter int STATE_COUNT  = 256,
    parameter int SYMBOL_COUNT = 64,
    parameter int RULE_COUNT   = 128,
    parameter int STACK_DEPTH  = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: reduce limit
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  table_state,
    input  wire logic [5:0]  table_symbol,
    input  wire logic [1:0]  entry_kind,
    input  wire logic [7:0]  entry_target,
    input  wire logic [6:0]  rule_index,
    input  wire logic [5:0]  rule_lhs,
    input  wire logic [3:0]  rule_length,
    input  wire logic [5:0]  token_symbol,
    // result items
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_kind,
    output logic [6:0]       production,
    output logic [7:0]       top_state,
    output logic             last
);

    logic [5:0]     reduce_limit_reg;
    logic           clearing;
    logic           cmd_valid;
    logic           cmd_pop;
    lrpe_pkg::cmd_t cmd;

    // the limit register takes a transfer in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduce_limit_reg <= 6'(lrpe_pkg::LIMIT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            reduce_limit_reg <= cfg_data;
        end
    end

    // front: classify items, drop out of range writes, queue commands
    lrpe_front #(
        .STATE_COUNT (STATE_COUNT),
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .RULE_COUNT  (RULE_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .table_state (table_state),
        .table_symbol(table_symbol),
        .entry_kind  (entry_kind),
        .entry_target(entry_target),
        .rule_index  (rule_index),
        .rule_lhs    (rule_lhs),
        .rule_length (rule_length),
        .token_symbol(token_symbol),
        .hold        (clearing),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // back: stores, stack and the per-token shift-reduce sequencer
    lrpe_back #(
        .STATE_COUNT (STATE_COUNT),
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .RULE_COUNT  (RULE_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .reduce_limit(reduce_limit_reg),
        .clearing    (clearing),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .production  (production),
        .top_state   (top_state),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== rtl/lrpe_checker.sv =====
// lrpe_checker: port-level assertions for the parser driver and its bind
`default_nettype none

module lrpe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] event_kind,
    input wire logic [6:0] production,
    input wire logic [7:0] top_state,
    input wire logic       last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(top_state))
    else $error("stalled result changed");

    // only reductions are non-final
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> event_kind == lrpe_pkg::EV_REDUCE)
    else $error("non-final result is not a reduce");

    // accept and rejections leave a fresh stack
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && event_kind != lrpe_pkg::EV_SHIFT |-> top_state == 8'd0)
    else $error("final result left a nonzero top state");

    // production is only named by reductions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != lrpe_pkg::EV_REDUCE |-> production == 7'd0)
    else $error("production set on a non-reduce result");

endmodule

bind lr_table_parse_engine_top lrpe_checker u_lrpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_kind(event_kind),
    .production(production),
    .top_state (top_state),
    .last      (last)
);

`default_nettype wire

// ===== sim/lr_table_parse_engine_checker.sv =====
// lr table parse engine checker: watches the channels, predicts the parse events and compares them
`timescale 1ns / 100ps

module lr_table_parse_engine_checker
    import lrpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] table_state,
    input  logic [5:0] table_symbol,
    input  logic [1:0] entry_kind,
    input  logic [7:0] entry_target,
    input  logic [6:0] rule_index,
    input  logic [5:0] rule_lhs,
    input  logic [3:0] rule_length,
    input  logic [5:0] token_symbol,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] event_kind,
    input  logic [6:0] production,
    input  logic [7:0] top_state,
    input  logic       last,
    output int         errors,
    output int         outstanding
);

    typedef struct packed {
        ev_kind_t   kind;
        logic [6:0] prod;
        logic [7:0] top;
        logic       last;
    } parse_event_t;

    localparam int TBL_ENTRIES = 16384;
    localparam int RULE_SLOTS  = 128;
    localparam int STACK_SLOTS = 256;

    logic [9:0] action_tbl [TBL_ENTRIES];   // kind in 9:8, target in 7:0
    logic [8:0] goto_tbl [TBL_ENTRIES];     // valid in 8, target in 7:0
    logic [9:0] rule_tbl [RULE_SLOTS];      // lhs in 9:4, length in 3:0
    logic [7:0] parse_stack [STACK_SLOTS];
    int         stack_depth;
    logic [5:0] reduce_cap;
    parse_event_t pending_events [$];

    assign outstanding = pending_events.size();

    function automatic void add_event(ev_kind_t k, logic [6:0] p, logic [7:0] t, logic l);
        parse_event_t e;
        e.kind = k;
        e.prod = p;
        e.top  = t;
        e.last = l;
        pending_events.push_back(e);
    endfunction

    function automatic void reject_token(ev_kind_t k);
        stack_depth    = 1;
        parse_stack[0] = 8'd0;
        add_event(k, 7'd0, 8'd0, 1'b1);
    endfunction

    function automatic void parse_token(logic [5:0] tok);
        logic [7:0] st;
        logic [9:0] act;
        logic [9:0] rule;
        logic [8:0] go;
        int         reductions;
        int         remain;
        reductions = 0;
        forever
        begin
            st  = parse_stack[stack_depth - 1];
            act = action_tbl[{st, tok}];
            case (act_kind_t'(act[9:8]))
                ACT_NONE:
                begin
                    reject_token(EV_NOACT);
                    return;
                end
                ACT_SHIFT:
                begin
                    if (stack_depth >= STACK_SLOTS)
                        reject_token(EV_STACK);
                    else
                    begin
                        parse_stack[stack_depth] = act[7:0];
                        stack_depth++;
                        add_event(EV_SHIFT, 7'd0, act[7:0], 1'b1);
                    end
                    return;
                end
                ACT_ACCEPT:
                begin
                    stack_depth    = 1;
                    parse_stack[0] = 8'd0;
                    add_event(EV_ACCEPT, 7'd0, 8'd0, 1'b1);
                    return;
                end
                default:
                begin
                    if (reductions >= reduce_cap)
                    begin
                        reject_token(EV_LIMIT);
                        return;
                    end
                    if (act[7:0] >= RULE_SLOTS)
                    begin
                        reject_token(EV_NOACT);
                        return;
                    end
                    rule = rule_tbl[act[6:0]];
                    if (rule[3:0] >= stack_depth)
                    begin
                        reject_token(EV_STACK);
                        return;
                    end
                    remain = stack_depth - rule[3:0];
                    if (remain >= STACK_SLOTS)
                    begin
                        reject_token(EV_STACK);
                        return;
                    end
                    go = goto_tbl[{parse_stack[remain - 1], rule[9:4]}];
                    if (!go[8])
                    begin
                        reject_token(EV_NOGOTO);
                        return;
                    end
                    parse_stack[remain] = go[7:0];
                    stack_depth = remain + 1;
                    reductions++;
                    add_event(EV_REDUCE, act[6:0], go[7:0], 1'b0);
                end
            endcase
        end
    endfunction

    function automatic void check_field(string name, int e, int a);
        if (e != a)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TBL_ENTRIES; i++)
            begin
                action_tbl[i] = '0;
                goto_tbl[i]   = '0;
            end
            for (int i = 0; i < RULE_SLOTS; i++)
                rule_tbl[i] = '0;
            parse_stack[0] = 8'd0;
            stack_depth    = 1;
            reduce_cap     = 6'(LIMIT_RESET);
            pending_events.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                reduce_cap = cfg_data;
            if (in_valid && !in_stall)
            begin
                case (func_t'(func))
                    FUNC_ACTION: action_tbl[{table_state, table_symbol}] = {entry_kind, entry_target};
                    FUNC_GOTO:   goto_tbl[{table_state, table_symbol}] = {entry_kind != 2'd0, entry_target};
                    FUNC_RULE:   rule_tbl[rule_index] = {rule_lhs, rule_length};
                    default:     parse_token(token_symbol);
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual kind %0d", $time,
                             event_kind);
                    errors++;
                end
                else
                begin
                    parse_event_t e;
                    e = pending_events.pop_front();
                    check_field("event_kind", e.kind, event_kind);
                    check_field("production", e.prod, production);
                    check_field("top_state", e.top, top_state);
                    check_field("last", e.last, last);
                end
            end
        end
    end

endmodule

// ===== sim/lr_table_parse_engine_top_tb.sv =====
// lr table parse engine testbench top: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module lr_table_parse_engine_top_tb;
    import lrpe_pkg::*;

    // generous bound: reset sweep plus every token at its worst under long stalls
    localparam int CYCLE_LIMIT = 2000000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] func;
    logic [7:0] table_state;
    logic [5:0] table_symbol;
    logic [1:0] entry_kind;
    logic [7:0] entry_target;
    logic [6:0] rule_index;
    logic [5:0] rule_lhs;
    logic [3:0] rule_length;
    logic [5:0] token_symbol;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] event_kind;
    logic [6:0] production;
    logic [7:0] top_state;
    logic       last;
    int         errors;
    int         outstanding;

    int         cycle_count;
    int         idle_pct;       // chance per cycle that the sender holds back
    int         stall_pct;      // chance per cycle that the receiver stalls
    int         hold_cycles;    // length of the next long receiver hold-off
    int         hold_requests;  // bumped by the stimulus to start a hold-off
    int         holds_seen;
    int         hold_left;
    bit         rule_ok [128];  // production slots written so far

    lr_table_parse_engine_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .table_state  (table_state),
        .table_symbol (table_symbol),
        .entry_kind   (entry_kind),
        .entry_target (entry_target),
        .rule_index   (rule_index),
        .rule_lhs     (rule_lhs),
        .rule_length  (rule_length),
        .token_symbol (token_symbol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .production   (production),
        .top_state    (top_state),
        .last         (last)
    );

    lr_table_parse_engine_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .table_state  (table_state),
        .table_symbol (table_symbol),
        .entry_kind   (entry_kind),
        .entry_target (entry_target),
        .rule_index   (rule_index),
        .rule_lhs     (rule_lhs),
        .rule_length  (rule_length),
        .token_symbol (token_symbol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .production   (production),
        .top_state    (top_state),
        .last         (last),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_requests != holds_seen)
        begin
            holds_seen = hold_requests;
            hold_left  = hold_cycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one input transfer; fields the function does not use carry random values
    task automatic send(func_t f, logic [7:0] st, logic [5:0] sym, logic [1:0] kind,
                        logic [7:0] tgt, logic [6:0] ridx, logic [5:0] lhs,
                        logic [3:0] len, logic [5:0] tok);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        table_state  <= st;
        table_symbol <= sym;
        entry_kind   <= kind;
        entry_target <= tgt;
        rule_index   <= ridx;
        rule_lhs     <= lhs;
        rule_length  <= len;
        token_symbol <= tok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_rule(logic [6:0] idx, logic [5:0] lhs, logic [3:0] len);
        send(FUNC_RULE, 8'($urandom), 6'($urandom), 2'($urandom), 8'($urandom), idx, lhs, len,
             6'($urandom));
        rule_ok[idx] = 1'b1;
    endtask

    // a reduce entry must never point at a production that was never written
    task automatic write_action(logic [7:0] st, logic [5:0] sym, act_kind_t kind, logic [7:0] tgt);
        if (kind == ACT_REDUCE && tgt < 128 && !rule_ok[tgt[6:0]])
            write_rule(tgt[6:0], 6'($urandom), 4'($urandom_range(2)));
        send(FUNC_ACTION, st, sym, kind, tgt, 7'($urandom), 6'($urandom), 4'($urandom),
             6'($urandom));
    endtask

    task automatic write_goto(logic [7:0] st, logic [5:0] sym, logic [1:0] vld, logic [7:0] tgt);
        send(FUNC_GOTO, st, sym, vld, tgt, 7'($urandom), 6'($urandom), 4'($urandom),
             6'($urandom));
    endtask

    task automatic send_token(logic [5:0] tok);
        send(FUNC_TOKEN, 8'($urandom), 6'($urandom), 2'($urandom), 8'($urandom), 7'($urandom),
             6'($urandom), 4'($urandom), tok);
    endtask

    task automatic set_limit(logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let every expected event arrive, then give a write a chance to retire
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // random grammar: parser states 0 and 16..22, terminals 32..35, nonterminals 40..43
    function automatic logic [7:0] gram_state(int i);
        return (i == 0) ? 8'd0 : 8'(15 + i);
    endfunction

    task automatic random_action(int s, int t);
        int        r;
        act_kind_t k;
        logic [7:0] tgt;
        r = $urandom_range(99);
        if (r < 40)
        begin
            k   = ACT_SHIFT;
            tgt = gram_state($urandom_range(7));
        end
        else if (r < 75)
        begin
            k   = ACT_REDUCE;
            tgt = 8'($urandom_range(8, 15));
        end
        else if (r < 85)
        begin
            k   = ACT_ACCEPT;
            tgt = 8'($urandom);
        end
        else
        begin
            k   = ACT_NONE;
            tgt = 8'($urandom);
        end
        write_action(gram_state(s), 6'(32 + t), k, tgt);
    endtask

    task automatic random_phase(int items);
        int r;
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(99);
            if (r < 75)
                send_token(6'(32 + $urandom_range(3)));
            else if (r < 83)
                random_action($urandom_range(7), $urandom_range(3));
            else if (r < 88)
                write_goto(gram_state($urandom_range(7)), 6'(40 + $urandom_range(3)),
                           ($urandom_range(9) != 0) ? 2'($urandom_range(1, 3)) : 2'd0,
                           gram_state($urandom_range(7)));
            else if (r < 91)
                write_rule(7'($urandom_range(8, 15)), 6'(40 + $urandom_range(3)),
                           4'($urandom_range(3)));
            else
            begin
                // noise: anything at all
                case (func_t'($urandom_range(3)))
                    FUNC_ACTION: write_action(8'($urandom), 6'($urandom),
                                              act_kind_t'($urandom_range(3)), 8'($urandom));
                    FUNC_GOTO:   write_goto(8'($urandom), 6'($urandom), 2'($urandom),
                                            8'($urandom));
                    FUNC_RULE:   write_rule(7'($urandom), 6'($urandom), 4'($urandom));
                    default:     send_token(6'($urandom));
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        func          = FUNC_ACTION;
        table_state   = '0;
        table_symbol  = '0;
        entry_kind    = '0;
        entry_target  = '0;
        rule_index    = '0;
        rule_lhs      = '0;
        rule_length   = '0;
        token_symbol  = '0;
        out_stall     = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        hold_requests = 0;
        holds_seen    = 0;
        hold_left     = 0;
        cycle_count   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes of every field and each special case
        set_limit(6'd63);
        write_rule(7'd127, 6'd63, 4'd0);
        write_rule(7'd0, 6'd10, 4'd1);
        write_rule(7'd1, 6'd12, 4'd0);
        write_rule(7'd2, 6'd11, 4'd15);
        write_action(8'd255, 6'd63, ACT_SHIFT, 8'd255);
        write_goto(8'd255, 6'd63, 2'd3, 8'd255);
        write_goto(8'd0, 6'd63, 2'd0, 8'd0);
        // shift, then reduce followed by accept
        write_action(8'd0, 6'd1, ACT_SHIFT, 8'd3);
        write_action(8'd3, 6'd2, ACT_REDUCE, 8'd0);
        write_goto(8'd0, 6'd10, 2'd1, 8'd4);
        write_action(8'd4, 6'd2, ACT_ACCEPT, 8'd0);
        send_token(6'd1);
        send_token(6'd2);
        // no action for the top symbol
        send_token(6'd63);
        // empty production looping on itself until the reduction cap
        write_action(8'd0, 6'd6, ACT_REDUCE, 8'd1);
        write_goto(8'd0, 6'd12, 2'd2, 8'd0);
        send_token(6'd6);
        // pop past the bottom of the stack
        write_action(8'd0, 6'd7, ACT_REDUCE, 8'd2);
        send_token(6'd7);
        // goto entry never made valid
        write_action(8'd0, 6'd8, ACT_REDUCE, 8'd127);
        send_token(6'd8);
        // production index beyond the rule store
        write_action(8'd0, 6'd9, ACT_REDUCE, 8'd200);
        send_token(6'd9);
        drain();

        // cap of one: one reduction then reject
        set_limit(6'd1);
        send_token(6'd6);
        send_token(6'd1);
        send_token(6'd2);

        // back-to-back shifts while the receiver holds off and the input backs up
        write_action(8'd0, 6'd5, ACT_SHIFT, 8'd9);
        write_action(8'd9, 6'd5, ACT_SHIFT, 8'd9);
        hold_cycles = 100;
        hold_requests++;
        for (int i = 0; i < 16; i++)
            send_token(6'd5);
        drain();

        // build the random grammar
        set_limit(6'($urandom_range(2, 62)));
        for (int r = 8; r < 16; r++)
            write_rule(7'(r), 6'(40 + $urandom_range(3)), 4'($urandom_range(3)));
        for (int s = 0; s < 8; s++)
            for (int t = 0; t < 4; t++)
            begin
                random_action(s, t);
                write_goto(gram_state(s), 6'(40 + t),
                           ($urandom_range(9) != 0) ? 2'($urandom_range(1, 3)) : 2'd0,
                           gram_state($urandom_range(7)));
            end

        // random phases under different idling, with a new cap between them
        idle_pct  = 0;
        stall_pct = 0;
        random_phase(10);
        drain();
        set_limit(6'd63);
        idle_pct  = 81;
        stall_pct = 0;
        random_phase(10);
        drain();
        set_limit(6'd1);
        idle_pct  = 0;
        stall_pct = 81;
        random_phase(10);
        drain();
        set_limit(6'($urandom_range(1, 63)));
        idle_pct  = 32;
        stall_pct = 32;
        random_phase(10);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lrpe_pkg.sv
rtl/lrpe_ram.sv
rtl/lrpe_front.sv
rtl/lrpe_back.sv
rtl/lr_table_parse_engine_top.sv
rtl/lrpe_checker.sv
sim/lr_table_parse_engine_checker.sv
sim/lr_table_parse_engine_top_tb.sv
